@@ src/fpa_pkg.sv @@
// Shared types, codes and saturation helpers for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    OpAdd = 4'd0, OpSub = 4'd1, OpMul = 4'd2, OpDiv = 4'd3,
    OpGt = 4'd4, OpGe = 4'd5, OpLt = 4'd6, OpLe = 4'd7,
    OpEq = 4'd8, OpNe = 4'd9, OpMin = 4'd10, OpMax = 4'd11,
    OpInc = 4'd12, OpDec = 4'd13, OpFromInt = 4'd14, OpToInt = 4'd15
  } op_e;

  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    op_e                req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               overflowed;
    logic               divide_by_zero;
  } res_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    op_e                op;
    logic [31:0]        val;
    logic               cmp;
    logic               ovf;
    logic               dz;
    logic signed [63:0] prod;
    logic [63:0]        num;
    logic [31:0]        den;
    logic [31:0]        rem;
    logic [31:0]        quo;
    logic               div_ovf;
    logic               div_neg;
  } pipe_t;

  // Clamp a signed 64-bit value to the 32-bit range.
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sd2147483647) begin
      s.val = 32'h7fff_ffff;
      s.ovf = 1'b1;
    end else if (v < -64'sd2147483648) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // Give a magnitude its sign, then clamp.
  function automatic sat_t sat_mag(input logic [63:0] mag, input logic neg);
    sat_t s;
    if (neg && mag > 64'h0000_0000_8000_0000) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end else if (!neg && mag > 64'h0000_0000_7fff_ffff) begin
      s.val = 32'h7fff_ffff;
      s.ovf = 1'b1;
    end else begin
      s.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

@@ src/fpa_pre.sv @@
// Front stage: simple operations, product, and divider set-up.
`default_nettype none
module fpa_pre #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  fpa_pkg::req_t  req_i,
  output fpa_pkg::pipe_t pipe_o
);

  logic signed [63:0] a64, b64;
  logic [31:0]        mag_a, mag_b;
  logic [63:0]        num;
  fpa_pkg::sat_t      s;

  assign a64   = 64'(req_i.operand_a);
  assign b64   = 64'(req_i.operand_b);
  assign mag_a = req_i.operand_a[31] ? 32'd0 - req_i.operand_a : req_i.operand_a;
  assign mag_b = req_i.operand_b[31] ? 32'd0 - req_i.operand_b : req_i.operand_b;
  assign num   = {32'd0, mag_a} << FRAC_BITS;

  always_comb begin
    pipe_o         = '0;
    pipe_o.op      = req_i.req_type;
    pipe_o.prod    = a64 * b64;
    pipe_o.num     = num;
    pipe_o.den     = mag_b;
    pipe_o.rem     = num[63:32];
    pipe_o.div_ovf = num >= {mag_b, 32'd0};
    pipe_o.div_neg = req_i.operand_a[31] ^ req_i.operand_b[31];
    s              = '0;
    case (req_i.req_type)
      fpa_pkg::OpAdd: s = fpa_pkg::sat64(a64 + b64);
      fpa_pkg::OpSub: s = fpa_pkg::sat64(a64 - b64);
      fpa_pkg::OpDiv: pipe_o.dz = (req_i.operand_b == 32'sd0);
      fpa_pkg::OpGt:  pipe_o.cmp = req_i.operand_a > req_i.operand_b;
      fpa_pkg::OpGe:  pipe_o.cmp = req_i.operand_a >= req_i.operand_b;
      fpa_pkg::OpLt:  pipe_o.cmp = req_i.operand_a < req_i.operand_b;
      fpa_pkg::OpLe:  pipe_o.cmp = req_i.operand_a <= req_i.operand_b;
      fpa_pkg::OpEq:  pipe_o.cmp = req_i.operand_a == req_i.operand_b;
      fpa_pkg::OpNe:  pipe_o.cmp = req_i.operand_a != req_i.operand_b;
      fpa_pkg::OpMin:
        s.val = (req_i.operand_a < req_i.operand_b) ? req_i.operand_a : req_i.operand_b;
      fpa_pkg::OpMax:
        s.val = (req_i.operand_a > req_i.operand_b) ? req_i.operand_a : req_i.operand_b;
      fpa_pkg::OpInc:     s = fpa_pkg::sat64(a64 + 64'sd1);
      fpa_pkg::OpDec:     s = fpa_pkg::sat64(a64 - 64'sd1);
      fpa_pkg::OpFromInt: s = fpa_pkg::sat64(a64 <<< FRAC_BITS);
      fpa_pkg::OpToInt:   s.val = 32'(req_i.operand_a >>> FRAC_BITS);
      default: s = '0;
    endcase
    pipe_o.val = s.val;
    pipe_o.ovf = s.ovf;
  end

endmodule
`default_nettype wire

@@ src/fpa_div_step.sv @@
// One restoring division step: yields quotient bit BIT.
`default_nettype none
module fpa_div_step #(
  parameter int unsigned BIT = 0
) (
  input  fpa_pkg::pipe_t pipe_i,
  output fpa_pkg::pipe_t pipe_o
);

  logic [32:0] trial;

  assign trial = {pipe_i.rem, pipe_i.num[BIT]};

  always_comb begin
    pipe_o = pipe_i;
    if (trial >= {1'b0, pipe_i.den}) begin
      pipe_o.rem      = 32'(trial - {1'b0, pipe_i.den});
      pipe_o.quo[BIT] = 1'b1;
    end else begin
      pipe_o.rem = trial[31:0];
    end
  end

endmodule
`default_nettype wire

@@ src/fpa_post.sv @@
// Final stage: round and clamp products and quotients, form the result word.
`default_nettype none
module fpa_post #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  fpa_pkg::pipe_t pipe_i,
  output fpa_pkg::res_t  res_o
);

  localparam logic [63:0] Half = (64'd1 << FRAC_BITS) >> 1;

  logic [63:0]   pmag, pround;
  logic [32:0]   qround;
  fpa_pkg::sat_t ms, ds;

  assign pmag   = pipe_i.prod[63] ? 64'd0 - pipe_i.prod : pipe_i.prod;
  assign pround = (pmag + Half) >> FRAC_BITS;
  assign ms     = fpa_pkg::sat_mag(pround, pipe_i.prod[63]);
  // Round half away: bump when twice the remainder reaches the divisor.
  assign qround = {1'b0, pipe_i.quo} + 33'({pipe_i.rem, 1'b0} >= {1'b0, pipe_i.den});
  assign ds     = fpa_pkg::sat_mag(pipe_i.div_ovf ? 64'hffff_ffff_ffff_ffff
                                                   : 64'(qround), pipe_i.div_neg);

  always_comb begin
    res_o.result_value   = pipe_i.val;
    res_o.compare_true   = pipe_i.cmp;
    res_o.overflowed     = pipe_i.ovf;
    res_o.divide_by_zero = pipe_i.dz;
    case (pipe_i.op)
      fpa_pkg::OpMul: begin
        res_o.result_value = ms.val;
        res_o.overflowed   = ms.ovf;
      end
      fpa_pkg::OpDiv: begin
        if (!pipe_i.dz) begin
          res_o.result_value = ds.val;
          res_o.overflowed   = ds.ovf;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/fixed_point_alu.sv @@
// pipe_q[0] takes the front-stage word, the divider stages follow, and res_q drives res_o.
// One word per cycle if res_o is not stalled; 32 one-bit divider stages set the depth.
// Each stage advances when empty or when the stage after it advances, so bubbles fill.
// Reset (rst_ni low, asynchronous) empties every stage; data registers are not cleared.
`default_nettype none
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output      logic           req_ready_o,
  input  wire fpa_pkg::req_t  req_i,
  output      logic           res_valid_o,
  input  wire logic           res_ready_i,
  output      fpa_pkg::res_t  res_o
);

  localparam int unsigned NStages = fpa_pkg::DivSteps + 1;

  fpa_pkg::pipe_t              pre;
  fpa_pkg::pipe_t              pipe_q [NStages];
  fpa_pkg::pipe_t              step_d [fpa_pkg::DivSteps];
  logic [NStages-1:0]          vld_q;
  logic [NStages-1:0]          en;
  logic                        out_en;
  logic                        res_valid_q;
  fpa_pkg::res_t               res_q, res_d;

  fpa_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (.req_i(req_i), .pipe_o(pre));

  for (genvar k = 0; k < fpa_pkg::DivSteps; k++) begin : g_div
    fpa_div_step #(.BIT(fpa_pkg::DivSteps - 1 - k)) u_step (
      .pipe_i(pipe_q[k]),
      .pipe_o(step_d[k])
    );
  end

  fpa_post #(.FRAC_BITS(FRAC_BITS)) u_post (.pipe_i(pipe_q[NStages-1]), .res_o(res_d));

  assign out_en = !res_valid_q || res_ready_i;

  for (genvar k = 0; k < NStages; k++) begin : g_en
    if (k == NStages - 1) begin : g_last
      assign en[k] = !vld_q[k] || out_en;
    end else begin : g_mid
      assign en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (en[0]) vld_q[0] <= req_valid_i;
      for (int k = 1; k < NStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
      if (out_en) res_valid_q <= vld_q[NStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && req_valid_i) pipe_q[0] <= pre;
    for (int k = 1; k < NStages; k++) begin
      if (en[k] && vld_q[k-1]) pipe_q[k] <= step_d[k-1];
    end
    if (out_en && vld_q[NStages-1]) res_q <= res_d;
  end

  assign req_ready_o = en[0];
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
